// ===== rtl/fuzzy_pi_dual_motor_controller_assert.svh =====
// Assertion macros for the fuzzy PI dual motor controller.
// Included by the top level; needs nothing else.
`ifndef FUZZY_PI_DUAL_MOTOR_CONTROLLER_ASSERT_SVH
`define FUZZY_PI_DUAL_MOTOR_CONTROLLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define FPDM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("fpdm assertion failed");
`define FPDM_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("fpdm forbidden condition seen");
`else
`define FPDM_ASSERT(lbl, clk, rst_n, prop)
`define FPDM_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== rtl/fpdm_pkg.sv =====
// Shared widths, constants and the helper function of the fuzzy PI controller.
// No dependencies.
`timescale 1ns / 1ps
package fpdm_pkg;
	localparam int SPEED_FRAC_BITS_DEF = 16;

	localparam int MUL_A_W = 27;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 32;
	localparam int DIV_D_W = 18;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [11:0] TENTH = 12'd3277;
	localparam logic [15:0] ONE_Q15 = 16'd32768;
	localparam logic [15:0] FORTY_PCT = 16'd13107;
	localparam logic [6:0] DUTY_MAX = 7'd100;

	localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE = 3'd5;

	// Sign and magnitude of a Q.24 product to Q1.15: clamp to +-1.0, then
	// shift right by 9 rounding toward minus infinity.
	function automatic logic signed [16:0] q15_of(input logic neg,
			input logic [MUL_P_W-1:0] mag);
		logic [24:0] c;
		logic [16:0] up;
		logic [16:0] dn;
		c = (mag > MUL_P_W'(25'h1000000)) ? 25'h1000000 : mag[24:0];
		up = 17'(c >> 9);
		dn = 17'((26'(c) + 26'd511) >> 9);
		return neg ? -$signed(dn) : $signed(up);
	endfunction
endpackage

// ===== rtl/fpdm_in_if.sv =====
// Input channel of the fuzzy PI controller: one control tick per beat.
// Depends on nothing.
`timescale 1ns / 1ps
interface fpdm_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] heading_error;
	logic [15:0] goal_distance;
	modport source (output valid, heading_error, goal_distance, input ready);
	modport sink (input valid, heading_error, goal_distance, output ready);
endinterface

// ===== rtl/fpdm_out_if.sv =====
// Result channel of the fuzzy PI controller: one result per beat.
// Depends on nothing.
`timescale 1ns / 1ps
interface fpdm_out_if;
	logic valid;
	logic ready;
	logic [15:0] left_compare;
	logic [15:0] right_compare;
	logic [6:0] left_duty;
	logic [6:0] right_duty;
	logic signed [15:0] fuzzy_step;
	logic stopped;
	modport source (output valid, left_compare, right_compare, left_duty,
		right_duty, fuzzy_step, stopped, input ready);
	modport sink (input valid, left_compare, right_compare, left_duty,
		right_duty, fuzzy_step, stopped, output ready);
endinterface

// ===== rtl/fpdm_cfg_if.sv =====
// Register write channel of the fuzzy PI controller.
// Uses the index and data widths of fpdm_pkg.
`timescale 1ns / 1ps
interface fpdm_cfg_if import fpdm_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [CFG_DATA_W-1:0] wr_data;
	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

// ===== rtl/fpdm_serial_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Uses widths from fpdm_pkg.
`timescale 1ns / 1ps
module fpdm_serial_mul import fpdm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic               busy,
	output logic               done,
	output logic [MUL_P_W-1:0] p
);
	localparam int CNT_W = $clog2(MUL_B_W + 1);

	logic [MUL_P_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [MUL_P_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(MUL_B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= MUL_P_W'(a);
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign p = acc_q;
endmodule

// ===== rtl/fpdm_serial_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Uses widths from fpdm_pkg.
`timescale 1ns / 1ps
module fpdm_serial_div import fpdm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DIV_N_W-1:0] n,
	input  logic [DIV_D_W-1:0] d,
	output logic               busy,
	output logic               done,
	output logic [DIV_N_W-1:0] q
);
	localparam int CNT_W = $clog2(DIV_N_W + 1);

	logic [DIV_N_W-1:0] dvd_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DIV_D_W:0] trial;
	logic fits;

	assign trial = {rem_q, dvd_q[DIV_N_W-1]};
	assign fits = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= n;
			dsr_q <= d;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_D_W'(trial - {1'b0, dsr_q}) : trial[DIV_D_W-1:0];
			dvd_q <= {dvd_q[DIV_N_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign q = dvd_q;
endmodule

// ===== rtl/fuzzy_pi_dual_motor_controller.sv =====
// Top level of the fuzzy PI dual motor controller: sequencer, state and registers.
// Depends on fpdm_pkg, the three channel interfaces, fpdm_serial_mul,
// fpdm_serial_div and the assertion macro header.
//
// Usage: each beat on in_ch is one control tick (heading error, goal distance).
// The block answers with exactly one beat on out_ch carrying the PWM compares,
// integer duties, the defuzzified correction and the stop flag. Registers are
// written over cfg (index, data) whenever the block is idle; cfg is always ready.
// One tick runs through a shared bit-serial multiplier (16 products) and a
// shared restoring divider (5 quotients). A new tick is taken in the cycle
// after the previous one has been handed to the output register.
// If the receiver stalls, the finished result waits in the output register while
// the next tick is already accepted and computed; its result waits until the
// register frees. Reset clears the stored error and both speeds and loads the
// register defaults; it also drops any pending result.
`timescale 1ns / 1ps
`include "fuzzy_pi_dual_motor_controller_assert.svh"
module fuzzy_pi_dual_motor_controller import fpdm_pkg::*; #(
	parameter int SPEED_FRAC_BITS = SPEED_FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	fpdm_in_if.sink    in_ch,
	fpdm_out_if.source out_ch,
	fpdm_cfg_if.sink   cfg
);
	// Speed keeps 7 integer bits; the step is scaled from Q.23 by a constant shift.
	localparam int SP_W = SPEED_FRAC_BITS + 7;
	localparam int LSH = (SPEED_FRAC_BITS > 23) ? (SPEED_FRAC_BITS - 23) : 0;
	localparam int RSH = (SPEED_FRAC_BITS > 23) ? 0 : (23 - SPEED_FRAC_BITS);
	localparam int DM_W = 32 + LSH;
	localparam int SUM_W = DM_W + 2;
	localparam logic [SUM_W-1:0] SPD_TOP = SUM_W'(DUTY_MAX) << SPEED_FRAC_BITS;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RATE = 4'd1;
	localparam logic [3:0] ST_XQ = 4'd2;
	localparam logic [3:0] ST_RQ = 4'd3;
	localparam logic [3:0] ST_MEM_S = 4'd4;
	localparam logic [3:0] ST_MEM_Z = 4'd5;
	localparam logic [3:0] ST_RULE = 4'd6;
	localparam logic [3:0] ST_NUM = 4'd7;
	localparam logic [3:0] ST_QUO = 4'd8;
	localparam logic [3:0] ST_STEP = 4'd9;
	localparam logic [3:0] ST_LMUL = 4'd10;
	localparam logic [3:0] ST_LDIV = 4'd11;
	localparam logic [3:0] ST_RMUL = 4'd12;
	localparam logic [3:0] ST_RDIV = 4'd13;
	localparam logic [3:0] ST_OUT = 4'd14;

	// Configuration registers.
	logic [15:0] eg_q, rg_q, ssg_q, period_q, stop_q;
	logic [9:0] tick_q;

	// Sequencer and tick state.
	logic [3:0] state_q;
	logic phase_q;
	logic [1:0] ei_q, ri_q;
	logic signed [15:0] err_q, last_err_q;
	logic [15:0] dist_q;
	logic [25:0] rate_mag_q;
	logic rate_neg_q;
	logic signed [16:0] xq_q, rq_q;
	logic [15:0] side_q, ez_q;
	logic [15:0] str_q [3][3];
	logic num_neg_q;
	logic [31:0] num_mag_q;
	logic [17:0] sum_q;
	logic signed [15:0] step_q;
	logic [SP_W-1:0] lspd_q, rspd_q;
	logic [6:0] ldut_q, rdut_q;
	logic [22:0] lprod_q, rprod_q;
	logic [15:0] lcmp_q, rcmp_q;

	// Output register.
	logic out_valid_q;
	logic [15:0] o_lcmp_q, o_rcmp_q;
	logic [6:0] o_ldut_q, o_rdut_q;
	logic signed [15:0] o_step_q;
	logic o_stop_q;

	// Arithmetic units.
	logic mul_start, mul_busy, mul_done;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic div_start, div_busy, div_done;
	logic [DIV_N_W-1:0] div_n;
	logic [DIV_D_W-1:0] div_d;
	logic [DIV_N_W-1:0] div_q;

	fpdm_serial_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .done(mul_done), .p(mul_p)
	);

	fpdm_serial_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .n(div_n), .d(div_d),
		.busy(div_busy), .done(div_done), .q(div_q)
	);

	// Derived values, taken from registers that hold still during a step or from the multiplier product.
	logic [16:0] diff, diff_abs, err_ext, err_abs, xq_abs, rq_abs, step_ext, step_abs;
	logic [11:0] ax_c;
	logic [15:0] e_n, e_p, r_n, r_z, r_p, e_sel, r_sel;
	logic [15:0] b_nb, b_ns, b_ze, b_ps, b_pb;
	logic [16:0] pb_nb, dps, dps_abs;
	logic [33:0] p40, num;
	logic use_div, in_step, unit_done, out_free, in_acc;

	assign diff = {err_q[15], err_q} - {last_err_q[15], last_err_q};
	assign diff_abs = diff[16] ? -diff : diff;
	assign err_ext = {err_q[15], err_q};
	assign err_abs = err_q[15] ? -err_ext : err_ext;

	// Memberships of the error: both side sets share one quotient.
	assign xq_abs = xq_q[16] ? 17'(-xq_q) : 17'(xq_q);
	assign ax_c = (xq_abs > 17'(TENTH)) ? TENTH : xq_abs[11:0];
	assign e_n = xq_q[16] ? side_q : 16'd0;
	assign e_p = xq_q[16] ? 16'd0 : side_q;

	// Memberships of the rate are linear in the clamped rate.
	assign rq_abs = rq_q[16] ? 17'(-rq_q) : 17'(rq_q);
	assign r_n = rq_q[16] ? rq_abs[15:0] : 16'd0;
	assign r_p = rq_q[16] ? 16'd0 : rq_abs[15:0];
	assign r_z = 16'(17'(ONE_Q15) - rq_abs);

	always_comb begin
		case (ei_q)
			2'd0: e_sel = e_n;
			2'd1: e_sel = ez_q;
			2'd2: e_sel = e_p;
			default: e_sel = 16'd0;
		endcase
		case (ri_q)
			2'd0: r_sel = r_n;
			2'd1: r_sel = r_z;
			2'd2: r_sel = r_p;
			default: r_sel = 16'd0;
		endcase
	end

	// Output sets merge by max over the rules that point at them.
	always_comb begin
		b_nb = str_q[0][0];
		b_ns = (str_q[0][1] > str_q[1][0]) ? str_q[0][1] : str_q[1][0];
		b_ze = (str_q[0][2] > str_q[1][1]) ? str_q[0][2] : str_q[1][1];
		b_ze = (b_ze > str_q[2][0]) ? b_ze : str_q[2][0];
		b_ps = (str_q[1][2] > str_q[2][1]) ? str_q[1][2] : str_q[2][1];
		b_pb = str_q[2][2];
	end

	assign pb_nb = {1'b0, b_pb} - {1'b0, b_nb};
	assign dps = {1'b0, b_ps} - {1'b0, b_ns};
	assign dps_abs = dps[16] ? -dps : dps;
	assign p40 = dps[16] ? -34'(mul_p[28:0]) : 34'(mul_p[28:0]);
	assign num = {{2{pb_nb[16]}}, pb_nb, 15'd0} + p40;

	assign step_ext = {step_q[15], step_q};
	assign step_abs = step_q[15] ? -step_ext : step_ext;

	// Speed update from the finished step product.
	logic [DM_W-1:0] dm;
	logic [SUM_W-1:0] sd, rsum, lsum;
	logic [SP_W-1:0] rnew, lnew;

	function automatic logic [SP_W-1:0] clamp_spd(input logic [SUM_W-1:0] s);
		if (s[SUM_W-1]) begin
			return '0;
		end else if (s > SPD_TOP) begin
			return SPD_TOP[SP_W-1:0];
		end
		return s[SP_W-1:0];
	endfunction

	assign dm = (DM_W'(mul_p[31:0]) << LSH) >> RSH;
	assign sd = step_q[15] ? -SUM_W'(dm) : SUM_W'(dm);
	assign rsum = SUM_W'(rspd_q) + sd;
	assign lsum = SUM_W'(lspd_q) - sd;
	assign rnew = clamp_spd(rsum);
	assign lnew = clamp_spd(lsum);

	// Operand selection for the unit owned by the current state.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_n = '0;
		div_d = '0;
		use_div = 1'b0;
		case (state_q)
			ST_RATE: begin
				mul_a = MUL_A_W'(diff_abs[15:0]);
				mul_b = MUL_B_W'(tick_q);
			end
			ST_XQ: begin
				mul_a = MUL_A_W'(err_abs[15:0]);
				mul_b = eg_q;
			end
			ST_RQ: begin
				mul_a = MUL_A_W'(rate_mag_q);
				mul_b = rg_q;
			end
			ST_MEM_S: begin
				use_div = 1'b1;
				div_n = DIV_N_W'({ax_c, 15'd0});
				div_d = DIV_D_W'(TENTH);
			end
			ST_MEM_Z: begin
				use_div = 1'b1;
				div_n = DIV_N_W'({12'(TENTH - ax_c), 15'd0});
				div_d = DIV_D_W'(TENTH);
			end
			ST_RULE: begin
				mul_a = MUL_A_W'(e_sel);
				mul_b = r_sel;
			end
			ST_NUM: begin
				mul_a = MUL_A_W'(dps_abs[15:0]);
				mul_b = FORTY_PCT;
			end
			ST_QUO: begin
				use_div = 1'b1;
				div_n = num_mag_q;
				div_d = sum_q;
			end
			ST_STEP: begin
				mul_a = MUL_A_W'(step_abs[15:0]);
				mul_b = ssg_q;
			end
			ST_LMUL: begin
				mul_a = MUL_A_W'(period_q);
				mul_b = MUL_B_W'(ldut_q);
			end
			ST_LDIV: begin
				use_div = 1'b1;
				div_n = DIV_N_W'(lprod_q);
				div_d = DIV_D_W'(DUTY_MAX);
			end
			ST_RMUL: begin
				mul_a = MUL_A_W'(period_q);
				mul_b = MUL_B_W'(rdut_q);
			end
			ST_RDIV: begin
				use_div = 1'b1;
				div_n = DIV_N_W'(rprod_q);
				div_d = DIV_D_W'(DUTY_MAX);
			end
			default: begin
			end
		endcase
	end

	// Each working state launches its unit once, then waits for its done pulse.
	assign in_step = (state_q != ST_IDLE) && (state_q != ST_OUT);
	assign mul_start = in_step && !phase_q && !use_div;
	assign div_start = in_step && !phase_q && use_div;
	assign unit_done = phase_q && (use_div ? div_done : mul_done);
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_acc = in_ch.valid && in_ch.ready;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eg_q <= 16'd12288;
			rg_q <= 16'd2048;
			ssg_q <= 16'd1280;
			tick_q <= 10'd10;
			period_q <= 16'd399;
			stop_q <= 16'd26;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				REG_ERROR_GAIN: eg_q <= cfg.wr_data;
				REG_RATE_GAIN: rg_q <= cfg.wr_data;
				REG_SPEED_STEP_GAIN: ssg_q <= cfg.wr_data;
				REG_TICK_RATE: tick_q <= cfg.wr_data[9:0];
				REG_PWM_PERIOD: period_q <= cfg.wr_data;
				REG_STOP_DISTANCE: stop_q <= cfg.wr_data;
				default: begin
				end
			endcase
		end
	end

	// Control state and the state carried from tick to tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			ei_q <= 2'd0;
			ri_q <= 2'd0;
			last_err_q <= '0;
			lspd_q <= '0;
			rspd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result may replace the one leaving in the same cycle.
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE) begin
				if (in_acc) begin
					state_q <= ST_RATE;
					phase_q <= 1'b0;
				end
			end else if (state_q == ST_OUT) begin
				if (out_free) begin
					state_q <= ST_IDLE;
				end
			end else if (!phase_q) begin
				phase_q <= 1'b1;
			end else if (unit_done) begin
				phase_q <= 1'b0;
				case (state_q)
					ST_MEM_Z: begin
						ei_q <= 2'd0;
						ri_q <= 2'd0;
						state_q <= ST_RULE;
					end
					ST_RULE: begin
						if (ri_q == 2'd2) begin
							ri_q <= 2'd0;
							if (ei_q == 2'd2) begin
								state_q <= ST_NUM;
							end else begin
								ei_q <= ei_q + 2'd1;
							end
						end else begin
							ri_q <= ri_q + 2'd1;
						end
					end
					ST_STEP: begin
						rspd_q <= rnew;
						lspd_q <= lnew;
						last_err_q <= err_q;
						state_q <= ST_LMUL;
					end
					default: begin
						state_q <= state_q + 4'd1;
					end
				endcase
			end
		end
	end

	// Datapath captures.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_q <= in_ch.heading_error;
			dist_q <= in_ch.goal_distance;
		end
		if (unit_done) begin
			case (state_q)
				ST_RATE: begin
					rate_mag_q <= mul_p[25:0];
					rate_neg_q <= diff[16];
				end
				ST_XQ: xq_q <= q15_of(err_q[15], mul_p);
				ST_RQ: rq_q <= q15_of(rate_neg_q, mul_p);
				ST_MEM_S: side_q <= div_q[15:0];
				ST_MEM_Z: ez_q <= div_q[15:0];
				ST_RULE: str_q[ei_q][ri_q] <= mul_p[30:15];
				ST_NUM: begin
					num_neg_q <= num[33];
					num_mag_q <= num[33] ? 32'(-num) : num[31:0];
					sum_q <= 18'(b_nb) + 18'(b_ns) + 18'(b_ze) + 18'(b_ps) + 18'(b_pb);
				end
				ST_QUO: begin
					if (sum_q == '0) begin
						step_q <= '0;
					end else if (num_neg_q) begin
						step_q <= (div_q > 32'd32768) ? 16'sh8000 : 16'(-div_q);
					end else begin
						step_q <= (div_q > 32'd32767) ? 16'sh7fff : 16'(div_q);
					end
				end
				ST_STEP: begin
					ldut_q <= lnew[SP_W-1:SPEED_FRAC_BITS];
					rdut_q <= rnew[SP_W-1:SPEED_FRAC_BITS];
				end
				ST_LMUL: lprod_q <= mul_p[22:0];
				ST_LDIV: lcmp_q <= div_q[15:0];
				ST_RMUL: rprod_q <= mul_p[22:0];
				ST_RDIV: rcmp_q <= div_q[15:0];
				default: begin
				end
			endcase
		end
		if ((state_q == ST_OUT) && out_free) begin
			o_stop_q <= (dist_q <= stop_q);
			o_lcmp_q <= (dist_q <= stop_q) ? 16'd0 : lcmp_q;
			o_rcmp_q <= (dist_q <= stop_q) ? 16'd0 : rcmp_q;
			o_ldut_q <= ldut_q;
			o_rdut_q <= rdut_q;
			o_step_q <= step_q;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.left_compare = o_lcmp_q;
	assign out_ch.right_compare = o_rcmp_q;
	assign out_ch.left_duty = o_ldut_q;
	assign out_ch.right_duty = o_rdut_q;
	assign out_ch.fuzzy_step = o_step_q;
	assign out_ch.stopped = o_stop_q;

	`FPDM_NEVER(a_units_exclusive, clk, arst_n, mul_busy && div_busy)
	`FPDM_ASSERT(a_leave_idle, clk, arst_n, in_acc |=> (state_q != ST_IDLE))
	`FPDM_ASSERT(a_stop_zero, clk, arst_n, (out_valid_q && o_stop_q) |-> ((o_lcmp_q | o_rcmp_q) == '0))
	`FPDM_ASSERT(a_duty_range, clk, arst_n, out_valid_q |-> ((o_ldut_q <= DUTY_MAX) && (o_rdut_q <= DUTY_MAX)))
endmodule
